/* src/rgbcvt_pkg.sv */
// ----------------------------------------------------------------------------
// rgbcvt_pkg - shared types and tables for the RGB pixel format converter
// Format codes, per-format channel layouts and the reciprocal constants
// that turn the rounding divide by a channel maximum into one multiply.
// ----------------------------------------------------------------------------
package rgbcvt_pkg;

    localparam int PIX_W   = 32;
    localparam int CHAN_W  = 8;
    localparam int POS_W   = 5;
    localparam int CW_W    = 4;
    localparam int NB_W    = 3;
    localparam int PROD_W  = 16;
    localparam int RECIP_W = 25;
    localparam int RECIP_K = 24;
    localparam int NCHAN   = 4;

    // Configuration register indexes
    localparam logic [1:0] CFG_SOURCE_FORMAT = 2'd0;
    localparam logic [1:0] CFG_DEST_FORMAT   = 2'd1;

    // Format codes
    localparam logic [7:0] FMT_R8G8B8   = 8'd20;
    localparam logic [7:0] FMT_A8R8G8B8 = 8'd21;
    localparam logic [7:0] FMT_X8R8G8B8 = 8'd22;
    localparam logic [7:0] FMT_R5G6B5   = 8'd23;
    localparam logic [7:0] FMT_X1R5G5B5 = 8'd24;
    localparam logic [7:0] FMT_A1R5G5B5 = 8'd25;
    localparam logic [7:0] FMT_A4R4G4B4 = 8'd26;

    // ceil(2^24 / D): exact rounding-free quotient for every numerator below 2^16
    localparam logic [RECIP_W-1:0] RECIP_255 = RECIP_W'((33'h1000000 + 33'd254) / 33'd255);
    localparam logic [RECIP_W-1:0] RECIP_63  = RECIP_W'((33'h1000000 + 33'd62) / 33'd63);
    localparam logic [RECIP_W-1:0] RECIP_31  = RECIP_W'((33'h1000000 + 33'd30) / 33'd31);
    localparam logic [RECIP_W-1:0] RECIP_15  = RECIP_W'((33'h1000000 + 33'd14) / 33'd15);
    localparam logic [RECIP_W-1:0] RECIP_1   = RECIP_W'(33'h1000000);

    typedef struct packed {
        logic [CHAN_W-1:0] max;
        logic [CW_W-1:0]   width;
        logic [POS_W-1:0]  pos;
    } t_chan;

    typedef struct packed {
        logic              known;
        logic [NB_W-1:0]   nbytes;
        t_chan             r;
        t_chan             g;
        t_chan             b;
        t_chan             a;
    } t_layout;

    function automatic t_chan mk_chan(input logic [CHAN_W-1:0] max,
                                      input logic [CW_W-1:0] width,
                                      input logic [POS_W-1:0] pos);
        t_chan c;
        c.max   = max;
        c.width = width;
        c.pos   = pos;
        return c;
    endfunction

    function automatic t_layout fmt_layout(input logic [7:0] code);
        t_layout l;
        l.known  = 1'b1;
        l.nbytes = 3'd2;
        l.r = mk_chan(8'd0, 4'd0, 5'd0);
        l.g = mk_chan(8'd0, 4'd0, 5'd0);
        l.b = mk_chan(8'd0, 4'd0, 5'd0);
        l.a = mk_chan(8'd0, 4'd0, 5'd0);
        case (code)
            FMT_R8G8B8: begin
                l.nbytes = 3'd3;
                l.r = mk_chan(8'd255, 4'd8, 5'd16);
                l.g = mk_chan(8'd255, 4'd8, 5'd8);
                l.b = mk_chan(8'd255, 4'd8, 5'd0);
            end
            FMT_A8R8G8B8: begin
                l.nbytes = 3'd4;
                l.r = mk_chan(8'd255, 4'd8, 5'd16);
                l.g = mk_chan(8'd255, 4'd8, 5'd8);
                l.b = mk_chan(8'd255, 4'd8, 5'd0);
                l.a = mk_chan(8'd255, 4'd8, 5'd24);
            end
            FMT_X8R8G8B8: begin
                l.nbytes = 3'd4;
                l.r = mk_chan(8'd255, 4'd8, 5'd16);
                l.g = mk_chan(8'd255, 4'd8, 5'd8);
                l.b = mk_chan(8'd255, 4'd8, 5'd0);
            end
            FMT_R5G6B5: begin
                l.r = mk_chan(8'd31, 4'd5, 5'd11);
                l.g = mk_chan(8'd63, 4'd6, 5'd5);
                l.b = mk_chan(8'd31, 4'd5, 5'd0);
            end
            FMT_X1R5G5B5: begin
                l.r = mk_chan(8'd31, 4'd5, 5'd10);
                l.g = mk_chan(8'd31, 4'd5, 5'd5);
                l.b = mk_chan(8'd31, 4'd5, 5'd0);
            end
            FMT_A1R5G5B5: begin
                l.r = mk_chan(8'd31, 4'd5, 5'd10);
                l.g = mk_chan(8'd31, 4'd5, 5'd5);
                l.b = mk_chan(8'd31, 4'd5, 5'd0);
                l.a = mk_chan(8'd1, 4'd1, 5'd15);
            end
            FMT_A4R4G4B4: begin
                l.r = mk_chan(8'd15, 4'd4, 5'd8);
                l.g = mk_chan(8'd15, 4'd4, 5'd4);
                l.b = mk_chan(8'd15, 4'd4, 5'd0);
                l.a = mk_chan(8'd15, 4'd4, 5'd12);
            end
            default: begin
                l.known = 1'b0;
            end
        endcase
        return l;
    endfunction

    function automatic logic [RECIP_W-1:0] recip(input logic [CHAN_W-1:0] smax);
        logic [RECIP_W-1:0] m;
        case (smax)
            8'd255:  m = RECIP_255;
            8'd63:   m = RECIP_63;
            8'd31:   m = RECIP_31;
            8'd15:   m = RECIP_15;
            8'd1:    m = RECIP_1;
            default: m = '0;
        endcase
        return m;
    endfunction

    function automatic logic [PIX_W-1:0] byte_mask(input logic [NB_W-1:0] nbytes);
        logic [PIX_W-1:0] m;
        case (nbytes)
            3'd2:    m = 32'h0000_FFFF;
            3'd3:    m = 32'h00FF_FFFF;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

/* src/rgb_pixel_format_converter.sv */
// ----------------------------------------------------------------------------
// rgb_pixel_format_converter - packed RGB pixel format conversion
// Converts pixels between seven packed RGB/ARGB formats with per-channel
// rounding rescale; unknown format codes flag an error and give zero.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | handshake
//  ---------+-------------------------------------------+------------------
//  input    | i_pixel_in                                | i_valid / o_ready
//  output   | o_pixel_out, o_format_error               | o_valid / i_ready
//  config   | i_cfg_index, i_cfg_wdata                  | i_cfg_we (write)
//
//  From accept to result a pixel passes an input register, then the channel
//  rescale (one reciprocal multiply per channel) into the result register.
//  One pixel per cycle is sustained while the output is taken. A stall on
//  i_ready holds both stages; o_ready then drops only once the input register
//  is also full. Reset clears both valid flags and sets both format registers
//  to A8R8G8B8.
// ----------------------------------------------------------------------------
module rgb_pixel_format_converter (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [rgbcvt_pkg::PIX_W-1:0] i_pixel_in,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [rgbcvt_pkg::PIX_W-1:0] o_pixel_out,
    output logic                         o_format_error,
    input  logic                         i_cfg_we,
    input  logic [1:0]                   i_cfg_index,
    input  logic [7:0]                   i_cfg_wdata
);
    import rgbcvt_pkg::*;

    logic [7:0]       r_src_fmt;
    logic [7:0]       r_dst_fmt;
    logic             r_s1_valid;
    logic [PIX_W-1:0] r_s1_pix;
    logic             r_out_valid;
    logic [PIX_W-1:0] r_out_pix;
    logic             r_out_err;

    logic             out_adv;
    logic             in_acc;
    t_layout          s_lay;
    t_layout          d_lay;
    logic [PIX_W-1:0] pix_m;
    logic             n_err;
    logic [PIX_W-1:0] n_pix;
    t_chan            src_ch [NCHAN];
    t_chan            dst_ch [NCHAN];
    logic [CHAN_W-1:0] ch_val [NCHAN];

    assign out_adv = !r_out_valid || i_ready;
    assign o_ready = !r_s1_valid || out_adv;
    assign in_acc  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_fmt <= FMT_A8R8G8B8;
            r_dst_fmt <= FMT_A8R8G8B8;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SOURCE_FORMAT: r_src_fmt <= i_cfg_wdata;
                CFG_DEST_FORMAT:   r_dst_fmt <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        s_lay = fmt_layout(r_src_fmt);
        d_lay = fmt_layout(r_dst_fmt);
        pix_m = r_s1_pix & byte_mask(s_lay.nbytes);
        src_ch[0] = s_lay.r;
        src_ch[1] = s_lay.g;
        src_ch[2] = s_lay.b;
        src_ch[3] = s_lay.a;
        dst_ch[0] = d_lay.r;
        dst_ch[1] = d_lay.g;
        dst_ch[2] = d_lay.b;
        dst_ch[3] = d_lay.a;
    end

    for (genvar c = 0; c < NCHAN; c++) begin : g_chan
        rgbcvt_chan u_chan (
            .i_pix   (pix_m),
            .i_src   (src_ch[c]),
            .i_dst   (dst_ch[c]),
            .o_value (ch_val[c])
        );
    end

    always_comb begin
        n_err = !s_lay.known || !d_lay.known;
        n_pix = '0;
        if (n_err) begin
            n_pix = '0;
        end else if (r_src_fmt == r_dst_fmt) begin
            n_pix = pix_m;
        end else begin
            for (int c = 0; c < NCHAN; c++) begin
                n_pix = n_pix | (PIX_W'(ch_val[c]) << dst_ch[c].pos);
            end
            n_pix = n_pix & byte_mask(d_lay.nbytes);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_s1_valid <= i_valid;
            end
            if (out_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_pix <= i_pixel_in;
        end
        if (out_adv && r_s1_valid) begin
            r_out_pix <= n_pix;
            r_out_err <= n_err;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_pixel_out    = r_out_pix;
    assign o_format_error = r_out_err;

    // an error result carries a zero pixel
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_err |-> r_out_pix == '0)
        else $error("format error result with nonzero pixel");

    // a filled input stage moves on unless the output is stalled
    a_s1_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !(r_out_valid && !i_ready) |=> r_out_valid)
        else $error("input stage did not advance to output");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_out_valid && !r_s1_valid)
        else $error("pipeline not empty after reset");

endmodule

/* src/rgbcvt_chan.sv */
// ----------------------------------------------------------------------------
// rgbcvt_chan - one color channel rescale
// Extracts a channel by shift and mask and rescales it to the destination
// range with rounding, using a reciprocal multiply for the divide.
// ----------------------------------------------------------------------------
module rgbcvt_chan (
    input  logic [rgbcvt_pkg::PIX_W-1:0]  i_pix,
    input  rgbcvt_pkg::t_chan             i_src,
    input  rgbcvt_pkg::t_chan             i_dst,
    output logic [rgbcvt_pkg::CHAN_W-1:0] o_value
);
    import rgbcvt_pkg::*;

    logic [CHAN_W-1:0]         v;
    logic [PROD_W-1:0]         num;
    logic [PROD_W+RECIP_W-1:0] prod;

    always_comb begin
        v    = CHAN_W'(i_pix >> i_src.pos) & i_src.max;
        // v * (2^w - 1) + smax/2, dmax is all ones so shift and subtract
        num  = (PROD_W'(v) << i_dst.width) - PROD_W'(v) + PROD_W'(i_src.max >> 1);
        prod = (PROD_W+RECIP_W)'(num) * (PROD_W+RECIP_W)'(recip(i_src.max));
        // missing source channel becomes full destination value
        if (i_src.max == '0) begin
            o_value = i_dst.max;
        end else begin
            o_value = prod[RECIP_K +: CHAN_W];
        end
    end

endmodule
